/* rtl/pama_pkg.sv */
// Package for the PLC area memory access block.
// Holds the transfer payload types, field codes and fixed widths.
// No dependencies; the interfaces, the top level and the testbench import it.
package pama_pkg;

  // Width of the configuration data bus (widest register).
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W     = 8;

  // Absolute address arithmetic: three 13-bit sizes plus 254 blocks of up to
  // 8191 bytes plus a 12-bit offset stays below 2**23.
  localparam int unsigned ADDR_W = 23;
  localparam int unsigned PROD_W = 21;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RST_INPUT_BYTES  = 13'd256;
  localparam logic [CFG_W-1:0] RST_OUTPUT_BYTES = 13'd256;
  localparam logic [CFG_W-1:0] RST_MARKER_BYTES = 13'd1024;
  localparam logic [CNT_W-1:0] RST_BLOCK_COUNT  = 8'd4;
  localparam logic [CFG_W-1:0] RST_BLOCK_BYTES  = 13'd512;

  // Operation codes.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Area codes.
  localparam logic [1:0] AREA_INPUT  = 2'd0;
  localparam logic [1:0] AREA_OUTPUT = 2'd1;
  localparam logic [1:0] AREA_MARKER = 2'd2;
  localparam logic [1:0] AREA_BLOCK  = 2'd3;

  // Access width codes.
  localparam logic [1:0] WID_BIT   = 2'd0;
  localparam logic [1:0] WID_BYTE  = 2'd1;
  localparam logic [1:0] WID_WORD  = 2'd2;
  localparam logic [1:0] WID_DWORD = 2'd3;

  // Status codes.
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [1:0]  area;
    logic [7:0]  block_num;
    logic [11:0] area_offset;
    logic [1:0]  access_width;
    logic [2:0]  bit_index;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
  } rsp_t;

endpackage

/* rtl/pama_req_if.sv */
// Request channel of the PLC area memory access block.
// Depends on pama_pkg for the payload type.
interface pama_req_if import pama_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/pama_rsp_if.sv */
// Response channel of the PLC area memory access block.
// Depends on pama_pkg for the payload type.
interface pama_rsp_if import pama_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/plc_area_memory_access_top.sv */
// Top level of the PLC area memory access block: sequencer, address unit,
// configuration registers. Depends on pama_pkg, pama_req_if, pama_rsp_if
// and pama_store.
//
//   Channel   Direction  Carries
//   req       in         operation, area, block_num, area_offset,
//                        access_width, bit_index, write_data
//   rsp       out        read_data, status
//   cfg_*     in         register index and data, write enable
//
// After reset the store is swept to zero, one byte per cycle; req.ready stays
// low during that sweep.
// One transfer is processed at a time. An item is taken in idle, passes the
// steps of the shared address adder and a check state, then writes one byte
// per access state, or reads each byte through an access state and a wait
// state (the store read port is registered); a bit access takes one access
// and one wait state. A failed check skips the store and offers the result.
// The result is held on rsp until it is taken; req.ready is low meanwhile.
module plc_area_memory_access_top import pama_pkg::*; #(
  parameter int unsigned POOL_BYTES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  pama_req_if.sink             req,
  pama_rsp_if.source           rsp
);

  localparam int unsigned AW = $clog2(POOL_BYTES);
  localparam logic [ADDR_W-1:0] PoolLimit = ADDR_W'(POOL_BYTES);
  localparam logic [AW-1:0]     LastByte  = AW'(POOL_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Adder steps.
  localparam logic [2:0] STEP_INPUT  = 3'd0;
  localparam logic [2:0] STEP_OUTPUT = 3'd1;
  localparam logic [2:0] STEP_MARKER = 3'd2;
  localparam logic [2:0] STEP_BLOCK  = 3'd3;
  localparam logic [2:0] STEP_OFFSET = 3'd4;

  // Configuration registers.
  logic [CFG_W-1:0] in_bytes_q, out_bytes_q, mk_bytes_q, blk_bytes_q;
  logic [CNT_W-1:0] blk_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bytes_q  <= RST_INPUT_BYTES;
      out_bytes_q <= RST_OUTPUT_BYTES;
      mk_bytes_q  <= RST_MARKER_BYTES;
      blk_cnt_q   <= RST_BLOCK_COUNT;
      blk_bytes_q <= RST_BLOCK_BYTES;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INPUT_BYTES:  in_bytes_q  <= cfg_data_i;
        REG_OUTPUT_BYTES: out_bytes_q <= cfg_data_i;
        REG_MARKER_BYTES: mk_bytes_q  <= cfg_data_i;
        REG_BLOCK_COUNT:  blk_cnt_q   <= cfg_data_i[CNT_W-1:0];
        REG_BLOCK_BYTES:  blk_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  logic [2:0]        state_q, state_d;
  logic [2:0]        step_q, step_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [1:0]        idx_q, idx_d;
  req_t              req_q, req_d;
  logic [ADDR_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] prod_q;
  logic [31:0]       rd_q, rd_d;
  logic              err_q, err_d;

  // Store port signals.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Derived item values.
  logic [2:0]        len;
  logic [1:0]        last_idx;
  logic [ADDR_W-1:0] opnd;
  logic [CFG_W-1:0]  limit;
  logic [CFG_W-1:0]  span;
  logic [ADDR_W-1:0] end_addr;
  logic              db_bad;
  logic [7:0]        bit_mask;
  logic [7:0]        bit_byte;

  always_comb begin
    case (req_q.access_width)
      WID_DWORD: len = 3'd4;
      WID_WORD:  len = 3'd2;
      default:   len = 3'd1;
    endcase
    last_idx = 2'(len - 3'd1);
  end

  // Block offset product, registered ahead of the adder step that uses it.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(req_q.block_num - 8'd1) * PROD_W'(blk_bytes_q);
  end

  // The shared adder accumulates the absolute address over five steps; an
  // operand that does not apply to the selected area is zero.
  always_comb begin
    opnd = '0;
    case (step_q)
      STEP_INPUT: begin
        if (req_q.area != AREA_INPUT) opnd = ADDR_W'(in_bytes_q);
      end
      STEP_OUTPUT: begin
        if (req_q.area == AREA_MARKER || req_q.area == AREA_BLOCK) begin
          opnd = ADDR_W'(out_bytes_q);
        end
      end
      STEP_MARKER: begin
        if (req_q.area == AREA_BLOCK) opnd = ADDR_W'(mk_bytes_q);
      end
      STEP_BLOCK: begin
        if (req_q.area == AREA_BLOCK) opnd = ADDR_W'(prod_q);
      end
      STEP_OFFSET: opnd = ADDR_W'(req_q.area_offset);
      default: opnd = '0;
    endcase
  end

  // Bounds and block number checks.
  always_comb begin
    case (req_q.area)
      AREA_INPUT:  limit = in_bytes_q;
      AREA_OUTPUT: limit = out_bytes_q;
      AREA_MARKER: limit = mk_bytes_q;
      default:     limit = blk_bytes_q;
    endcase
    span     = CFG_W'(req_q.area_offset) + CFG_W'(len);
    end_addr = acc_q + ADDR_W'(len);
    db_bad   = (req_q.area == AREA_BLOCK) &&
               (req_q.block_num == 8'd0 || req_q.block_num > blk_cnt_q);
  end

  assign bit_mask  = 8'd1 << req_q.bit_index;
  assign bit_byte  = req_q.write_data[0] ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
  assign mem_raddr = acc_q[AW-1:0] + AW'(idx_q);

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    req_d     = req_q;
    acc_d     = acc_q;
    rd_d      = rd_q;
    err_d     = err_q;
    mem_we    = 1'b0;
    mem_waddr = mem_raddr;
    mem_wdata = 8'd0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastByte) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          req_d   = req.payload;
          acc_d   = '0;
          step_d  = STEP_INPUT;
          idx_d   = 2'd0;
          rd_d    = 32'd0;
          err_d   = ST_OK;
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        acc_d  = acc_q + opnd;
        step_d = step_q + 3'd1;
        if (step_q == STEP_OFFSET) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (db_bad || span > limit || end_addr > PoolLimit) begin
          err_d   = ST_ERR;
          state_d = S_DONE;
        end else begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (req_q.operation == OP_WRITE && req_q.access_width != WID_BIT) begin
          mem_we    = 1'b1;
          mem_wdata = 8'(req_q.write_data >> {idx_q, 3'b000});
          if (idx_q == last_idx) begin
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end else begin
          // Read address is presented now; the byte arrives next cycle.
          state_d = S_RDW;
        end
      end
      S_RDW: begin
        if (req_q.access_width == WID_BIT) begin
          if (req_q.operation == OP_WRITE) begin
            mem_we    = 1'b1;
            mem_wdata = bit_byte;
          end else begin
            rd_d = 32'(mem_rdata[req_q.bit_index]);
          end
          state_d = S_DONE;
        end else begin
          rd_d = rd_q | (32'(mem_rdata) << {idx_q, 3'b000});
          if (idx_q == last_idx) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = S_ACC;
          end
        end
      end
      S_DONE: begin
        if (rsp.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      step_q  <= STEP_INPUT;
      idx_q   <= 2'd0;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    acc_q <= acc_d;
    rd_q  <= rd_d;
  end

  pama_store #(
    .DEPTH(POOL_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req.ready             = (state_q == S_IDLE);
  assign rsp.valid             = (state_q == S_DONE);
  assign rsp.payload.read_data = rd_q;
  assign rsp.payload.status    = err_q;

endmodule

/* rtl/pama_store.sv */
// Byte-wide process image store: one write port, one registered read port.
// Standalone; used by plc_area_memory_access_top.
module pama_store #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/pama_tb_pkg.sv */
// Scoreboard for the PLC area memory access testbench: a mirror of the
// byte image and the layout registers, plus the queue of pending results.
// Depends on pama_pkg for the payload types, field codes and reset values.
package pama_tb_pkg;
  import pama_pkg::*;

  localparam int unsigned IMAGE_BYTES = 4096;

  class process_image_scoreboard;
    int unsigned input_bytes;
    int unsigned output_bytes;
    int unsigned marker_bytes;
    int unsigned block_count;
    int unsigned block_bytes;
    int unsigned failures;
    logic [7:0]  image [IMAGE_BYTES];
    rsp_t        expected_results [$];

    function new();
      foreach (image[i]) image[i] = '0;
      input_bytes  = 32'(RST_INPUT_BYTES);
      output_bytes = 32'(RST_OUTPUT_BYTES);
      marker_bytes = 32'(RST_MARKER_BYTES);
      block_count  = 32'(RST_BLOCK_COUNT);
      block_bytes  = 32'(RST_BLOCK_BYTES);
      failures     = 0;
    endfunction

    // Only the low eight bits of the block count are kept; other indexes are dropped.
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_INPUT_BYTES:  input_bytes  = 32'(value);
        REG_OUTPUT_BYTES: output_bytes = 32'(value);
        REG_MARKER_BYTES: marker_bytes = 32'(value);
        REG_BLOCK_COUNT:  block_count  = 32'(value[CNT_W-1:0]);
        REG_BLOCK_BYTES:  block_bytes  = 32'(value);
        default: ;
      endcase
    endfunction

    static function int unsigned access_bytes(logic [1:0] wid);
      case (wid)
        WID_DWORD: return 4;
        WID_WORD:  return 2;
        default:   return 1;
      endcase
    endfunction

    function int unsigned area_bytes(logic [1:0] area);
      case (area)
        AREA_INPUT:  return input_bytes;
        AREA_OUTPUT: return output_bytes;
        AREA_MARKER: return marker_bytes;
        default:     return block_bytes;
      endcase
    endfunction

    // Applies one access to the image and returns the result it should give.
    function rsp_t resolve_access(req_t r);
      rsp_t        res;
      int unsigned len;
      int unsigned base;
      int unsigned addr;
      len = access_bytes(r.access_width);
      res.read_data = '0;
      res.status = ST_ERR;
      case (r.area)
        AREA_INPUT:  base = 0;
        AREA_OUTPUT: base = input_bytes;
        AREA_MARKER: base = input_bytes + output_bytes;
        default: begin
          if (r.block_num == 8'd0 || 32'(r.block_num) > block_count) return res;
          base = input_bytes + output_bytes + marker_bytes
               + (32'(r.block_num) - 1) * block_bytes;
        end
      endcase
      if (32'(r.area_offset) + len > area_bytes(r.area)) return res;
      if (base + 32'(r.area_offset) + len > IMAGE_BYTES) return res;
      addr = base + 32'(r.area_offset);
      res.status = ST_OK;
      if (r.access_width == WID_BIT) begin
        if (r.operation == OP_WRITE) image[addr][r.bit_index] = r.write_data[0];
        else res.read_data = 32'(image[addr][r.bit_index]);
      end else begin
        for (int unsigned i = 0; i < len; i++) begin
          if (r.operation == OP_WRITE) image[addr + i] = r.write_data[8*i +: 8];
          else res.read_data[8*i +: 8] = image[addr + i];
        end
      end
      return res;
    endfunction

    function void note_access(req_t r);
      expected_results.push_back(resolve_access(r));
    endfunction

    function void check_result(rsp_t got, time stamp);
      rsp_t want;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0d ns: result with no access pending, expected none, got %h/%b",
                 stamp, got.read_data, got.status);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_data !== want.read_data) begin
        failures++;
        $display("%0d ns: read_data expected %h, got %h", stamp, want.read_data, got.read_data);
      end
      if (got.status !== want.status) begin
        failures++;
        $display("%0d ns: status expected %b, got %b", stamp, want.status, got.status);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

/* sim/tb.sv */
// Testbench top for plc_area_memory_access_top: drives access transfers and
// layout writes, and checks every result against the image scoreboard.
// Depends on pama_pkg, pama_tb_pkg and the request and response interfaces.
module tb;
  import pama_pkg::*;
  import pama_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The receiver holds off this long once, so the block fills up and the
  // request side stalls while the sender keeps offering.
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  pama_req_if req ();
  pama_rsp_if rsp ();

  plc_area_memory_access_top #(
    .POOL_BYTES (IMAGE_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req),
    .rsp        (rsp)
  );

  process_image_scoreboard sb = new();

  // When steady is set, neither side inserts idle cycles any more.
  bit steady = 1'b0;
  // Raised by the stimulus process; the result process turns it into a long stall.
  bit hold_off_request = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on the run. The slowest correct run needs well under a fifth of this.
  initial begin
    #5_000_000;
    $display("plc_area_memory_access_top verification failed");
    $finish;
  end

  // Builds one access item from its fields.
  function automatic req_t make_access(logic op, logic [1:0] area, logic [7:0] dbn,
                                       logic [11:0] off, logic [1:0] wid,
                                       logic [2:0] bit_pos, logic [31:0] data);
    req_t r;
    r.operation    = op;
    r.area         = area;
    r.block_num    = dbn;
    r.area_offset  = off;
    r.access_width = wid;
    r.bit_index    = bit_pos;
    r.write_data   = data;
    return r;
  endfunction

  // Most random accesses are aimed inside the current layout: a valid block
  // number and an offset that keeps the access inside its area, clustered at
  // the start and the end of the area so that reads tend to find data written
  // earlier. One in five keeps fully random fields, which mostly fail the
  // block-number or bounds checks.
  function automatic req_t random_access();
    req_t        r;
    int unsigned len;
    int unsigned span;
    int unsigned top;
    r.operation    = 1'($urandom_range(0, 1));
    r.area         = 2'($urandom_range(0, 3));
    r.block_num    = 8'($urandom_range(0, 255));
    r.area_offset  = 12'($urandom_range(0, 4095));
    r.access_width = 2'($urandom_range(0, 3));
    r.bit_index    = 3'($urandom_range(0, 7));
    r.write_data   = $urandom();
    if ($urandom_range(0, 4) != 0) begin
      len = process_image_scoreboard::access_bytes(r.access_width);
      if (r.area == AREA_BLOCK && sb.block_count != 0)
        r.block_num = 8'($urandom_range(1, sb.block_count));
      span = sb.area_bytes(r.area);
      if (span >= len) begin
        top = span - len;
        if (top > 4095) top = 4095;
        case ($urandom_range(0, 2))
          0:       r.area_offset = 12'($urandom_range(0, (top < 15) ? top : 15));
          1:       r.area_offset = 12'($urandom_range((top < 15) ? 0 : top - 15, top));
          default: r.area_offset = 12'($urandom_range(0, top));
        endcase
      end
    end
    return r;
  endfunction

  // Offers one access and returns right after the edge at which it is taken.
  // Valid stays high into the next call unless that call opens a gap, so each
  // time step sees at most one assignment to it.
  task automatic send_access(input req_t r);
    if (!steady && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.payload <= r;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    sb.note_access(r);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_access(random_access());
  endtask

  // Stops offering and waits until every pending result has been taken,
  // plus a few cycles for the block to return to idle.
  task automatic drain_results();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write enable is left high; the caller lowers it after the last write.
  task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_register(idx, value);
  endtask

  // Rewrites the whole layout while the block is idle. Each layout change also
  // writes one unused index with junk, which the block must ignore.
  task automatic program_layout(input logic [CFG_W-1:0] in_b, input logic [CFG_W-1:0] out_b,
                                input logic [CFG_W-1:0] mk_b, input logic [CFG_W-1:0] cnt,
                                input logic [CFG_W-1:0] blk_b);
    put_register(REG_INPUT_BYTES, in_b);
    put_register(REG_OUTPUT_BYTES, out_b);
    put_register(REG_MARKER_BYTES, mk_b);
    put_register(REG_BLOCK_COUNT, cnt);
    put_register(REG_BLOCK_BYTES, blk_b);
    put_register(CFG_IDX_W'($urandom_range(int'(REG_BLOCK_BYTES) + 1, (1 << CFG_IDX_W) - 1)),
                 CFG_W'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  // Result side: checks each transfer and decides ready for the next cycle.
  // Short stalls come in random bursts; the long hold is counted here.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) sb.check_result(rsp.payload, $time);
      if (hold_off_request) begin
        stall_left = LONG_HOLD_CYCLES;
        hold_off_request = 1'b0;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    req.valid   <= 1'b0;
    req.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed accesses on the reset layout (input 256, output 256, marker
    // 1024, four blocks of 512). The block sweeps its store after reset, so
    // the first transfer waits on ready until the sweep is done.
    send_access(make_access(OP_WRITE, AREA_INPUT, 8'd0, 12'd0, WID_DWORD, 3'd0, 32'hFFFF_FFFF));
    send_access(make_access(OP_READ, AREA_INPUT, 8'd0, 12'd0, WID_DWORD, 3'd0, 32'h0));
    // A bit write takes bit 0 of the data only; this one clears bit 3.
    send_access(make_access(OP_WRITE, AREA_INPUT, 8'd0, 12'd0, WID_BIT, 3'd3, 32'hFFFF_FFFE));
    send_access(make_access(OP_READ, AREA_INPUT, 8'd0, 12'd0, WID_BYTE, 3'd0, 32'h0));
    send_access(make_access(OP_READ, AREA_INPUT, 8'd0, 12'd0, WID_BIT, 3'd3, 32'h0));
    send_access(make_access(OP_READ, AREA_INPUT, 8'd0, 12'd0, WID_BIT, 3'd7, 32'h0));
    send_access(make_access(OP_WRITE, AREA_INPUT, 8'd0, 12'd5, WID_BIT, 3'd7, 32'h0000_0001));
    send_access(make_access(OP_READ, AREA_INPUT, 8'd0, 12'd4, WID_WORD, 3'd0, 32'h0));
    // Word at the very end of the output area, then one byte past it.
    send_access(make_access(OP_WRITE, AREA_OUTPUT, 8'd0, 12'd254, WID_WORD, 3'd0, 32'h5A5A_A5C3));
    send_access(make_access(OP_READ, AREA_OUTPUT, 8'd0, 12'd254, WID_WORD, 3'd0, 32'h0));
    send_access(make_access(OP_WRITE, AREA_OUTPUT, 8'd0, 12'd255, WID_WORD, 3'd0, 32'h1234));
    // Little-endian order: the top byte of the dword lands at the highest address.
    send_access(make_access(OP_WRITE, AREA_MARKER, 8'd0, 12'd1020, WID_DWORD, 3'd0,
                            32'h1234_5678));
    send_access(make_access(OP_READ, AREA_MARKER, 8'd0, 12'd1023, WID_BYTE, 3'd0, 32'h0));
    send_access(make_access(OP_READ, AREA_MARKER, 8'd0, 12'd1021, WID_DWORD, 3'd0, 32'h0));
    send_access(make_access(OP_WRITE, AREA_BLOCK, 8'd4, 12'd511, WID_BYTE, 3'd0, 32'hFFFF_FF80));
    send_access(make_access(OP_READ, AREA_BLOCK, 8'd4, 12'd511, WID_BYTE, 3'd0, 32'h0));
    send_access(make_access(OP_READ, AREA_BLOCK, 8'd4, 12'd509, WID_DWORD, 3'd0, 32'h0));
    // Block numbers zero, one past the count and the largest are all invalid.
    send_access(make_access(OP_READ, AREA_BLOCK, 8'd0, 12'd0, WID_BYTE, 3'd0, 32'h0));
    send_access(make_access(OP_READ, AREA_BLOCK, 8'd5, 12'd0, WID_BYTE, 3'd0, 32'h0));
    send_access(make_access(OP_WRITE, AREA_BLOCK, 8'd255, 12'd0, WID_BYTE, 3'd0, 32'hFF));
    // A read ignores write data.
    send_access(make_access(OP_READ, AREA_BLOCK, 8'd1, 12'd0, WID_WORD, 3'd0, 32'hDEAD_BEEF));
    send_access(make_access(OP_READ, AREA_INPUT, 8'd0, 12'd4095, WID_BYTE, 3'd0, 32'h0));
    send_access(make_access(OP_READ, AREA_INPUT, 8'd0, 12'd255, WID_BIT, 3'd0, 32'h0));
    send_random(200);

    // Tiny areas and the block count written above its range (kept as 255).
    // The last blocks lie past the end of the store, the one holding its
    // final bytes does not.
    drain_results();
    program_layout(13'd16, 13'd16, 13'd32, 13'h1FF, 13'd16);
    send_access(make_access(OP_READ, AREA_BLOCK, 8'd255, 12'd0, WID_BYTE, 3'd0, 32'h0));
    send_access(make_access(OP_WRITE, AREA_BLOCK, 8'd252, 12'd15, WID_BYTE, 3'd0, 32'hC3));
    send_access(make_access(OP_READ, AREA_BLOCK, 8'd252, 12'd15, WID_BYTE, 3'd0, 32'h0));
    send_access(make_access(OP_WRITE, AREA_BLOCK, 8'd252, 12'd12, WID_DWORD, 3'd0,
                            32'h8765_4321));
    send_random(250);

    // One input area spanning the whole store; every other area is empty and
    // there are no blocks. Halfway through, the sender waits for all results.
    drain_results();
    program_layout(13'd4096, 13'd0, 13'd0, 13'd0, 13'd0);
    send_random(75);
    drain_results();
    send_random(75);

    // Every register at its largest value: only the input area stays inside.
    drain_results();
    program_layout(13'd8191, 13'd8191, 13'd8191, 13'd255, 13'd8191);
    send_random(100);

    // Data blocks only, starting at address zero. The receiver stalls for a
    // long stretch partway through while items keep being offered.
    drain_results();
    program_layout(13'd0, 13'd0, 13'd0, 13'd8, 13'd512);
    send_random(100);
    hold_off_request = 1'b1;
    send_random(150);

    // A layout that fills the store exactly, last block included.
    drain_results();
    program_layout(13'd64, 13'd64, 13'd128, 13'd30, 13'd128);
    send_random(350);

    // Back to the reset layout; the last stretch runs with no idling at all.
    drain_results();
    program_layout(RST_INPUT_BYTES, RST_OUTPUT_BYTES, RST_MARKER_BYTES,
                   CFG_W'(RST_BLOCK_COUNT), RST_BLOCK_BYTES);
    send_random(250);
    steady = 1'b1;
    send_random(300);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("plc_area_memory_access_top verification clean");
    end else begin
      $display("plc_area_memory_access_top verification failed");
    end
    $finish;
  end

endmodule
